>>> rtl/core/face_instance_slot_table_top_defines.svh
// Assertion macros shared by the face instance slot table RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef FACE_INSTANCE_SLOT_TABLE_TOP_DEFINES_SVH
`define FACE_INSTANCE_SLOT_TABLE_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define FIST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent, outside reset.
`define FIST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/fist_pkg.sv
// Types and codes of the face instance slot table.
// Depends on nothing; used by face_instance_slot_table_top and the testbench.
package fist_pkg;

    localparam logic [1:0] FUNC_SET    = 2'd0;
    localparam logic [1:0] FUNC_ADD    = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;
    localparam logic [1:0] FUNC_UPDATE = 2'd3;

    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_APPEND  = 2'd1;
    localparam logic [1:0] ACT_REUSE   = 2'd2;
    localparam logic [1:0] ACT_REMOVE  = 2'd3;

    localparam int unsigned NUM_FACES = 6;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  pos_x;
        logic [3:0]  pos_y;
        logic [3:0]  pos_z;
        logic [2:0]  face_num;
        logic [15:0] block_kind;
        logic [2:0]  block_orient;
        logic [15:0] neighbour_kind;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [14:0] slot_index;
        logic [3:0]  out_x;
        logic [3:0]  out_y;
        logic [3:0]  out_z;
        logic [2:0]  out_face;
        logic [2:0]  out_orient;
        logic [15:0] out_kind;
        logic [15:0] removed_count;
        logic        full_error;
    } out_word_t;

    typedef struct packed {
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  z;
        logic [2:0]  face;
        logic [2:0]  orient;
        logic [15:0] kind;
    } inst_t;

endpackage

>>> rtl/core/face_instance_slot_table_top.sv
// Top level of the face instance slot table: sequencer, memories, counters.
// Depends on fist_pkg, fist_ram and face_instance_slot_table_top_defines.svh.
//
// One word is taken at a time. After reset a clearing pass writes every
// block-store and key-map row, one row per cycle, before the first word is
// accepted. A set block, an add or an in-range word that changes nothing
// runs accept, memory read, execute and result load; a word out of range
// goes from accept straight to result load. A removal adds the instance
// read and remove states to fetch and rewrite the stored instance. The
// result is staged and then moved to the output register, so the next
// word is accepted while a result waits; the sequencer holds in its last
// state only while the previous result has not been taken.
`include "face_instance_slot_table_top_defines.svh"
module face_instance_slot_table_top #(
    parameter int SIDE      = 16,
    parameter int MAX_SLOTS = 32768
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  fist_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output fist_pkg::out_word_t  m_data
);
    import fist_pkg::*;

    localparam int CB = $clog2(SIDE);
    localparam int CAW = 3 * CB;
    localparam int ROWS = 1 << CAW;
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int CW = SW + 1;
    localparam int KW = NUM_FACES * (SW + 1);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_IREAD, ST_REM, ST_WAIT
    } state_t;

    state_t state_reg, state_next;
    in_word_t in_reg, in_next;
    logic [CAW-1:0] clr_reg, clr_next;
    logic [CW-1:0] free_top_reg, used_len_reg, free_top_next, used_len_next;
    logic [15:0] removed_reg, removed_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic out_valid_reg, out_valid_next;
    out_word_t out_reg, out_next;
    out_word_t res_reg, res_next;

    logic [CAW-1:0] cell_addr;
    logic [18:0] blk_rdata;
    logic blk_we;
    logic [18:0] blk_wdata;
    logic [KW-1:0] key_rdata, key_wdata;
    logic key_we;
    logic inst_we;
    logic [SW-1:0] inst_waddr, inst_raddr;
    inst_t inst_wdata, inst_rdata;
    logic fs_we;
    logic [SW-1:0] fs_waddr, fs_raddr, fs_rdata;
    logic in_range, can_take;
    logic [2:0] face_c;
    logic key_valid;
    logic [SW-1:0] key_slot;

    assign in_range = (32'(s_data.pos_x) < 32'(SIDE)) &&
        (32'(s_data.pos_y) < 32'(SIDE)) && (32'(s_data.pos_z) < 32'(SIDE));
    assign can_take = (state_reg == ST_IDLE);
    assign s_ready = can_take;
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    assign cell_addr = (state_reg == ST_CLEAR) ? clr_reg :
        {CB'(in_reg.pos_z), CB'(in_reg.pos_y), CB'(in_reg.pos_x)};
    assign face_c = in_reg.face_num;
    assign key_valid = key_rdata[face_c*(SW+1) + SW];
    assign key_slot = key_rdata[face_c*(SW+1) +: SW];

    fist_ram #(.WIDTH(19), .DEPTH(ROWS)) u_blk (
        .aclk(aclk), .we(blk_we), .waddr(cell_addr), .wdata(blk_wdata),
        .raddr(cell_addr), .rdata(blk_rdata));
    fist_ram #(.WIDTH(KW), .DEPTH(ROWS)) u_key (
        .aclk(aclk), .we(key_we), .waddr(cell_addr), .wdata(key_wdata),
        .raddr(cell_addr), .rdata(key_rdata));
    fist_ram #(.WIDTH($bits(inst_t)), .DEPTH(MAX_SLOTS)) u_inst (
        .aclk(aclk), .we(inst_we), .waddr(inst_waddr), .wdata(inst_wdata),
        .raddr(inst_raddr), .rdata(inst_rdata));
    fist_ram #(.WIDTH(SW), .DEPTH(MAX_SLOTS)) u_fs (
        .aclk(aclk), .we(fs_we), .waddr(fs_waddr), .wdata(slot_reg),
        .raddr(fs_raddr), .rdata(fs_rdata));

    // Decision in the execute state.
    logic do_add, do_rem, is_set;
    logic [15:0] add_kind;
    logic [2:0] add_orient;
    always_comb begin
        do_add = 1'b0;
        do_rem = 1'b0;
        is_set = (in_reg.func == FUNC_SET);
        add_kind = in_reg.block_kind;
        add_orient = in_reg.block_orient;
        if (!is_set && in_reg.face_num < 3'd6) begin
            case (in_reg.func)
                FUNC_ADD: do_add = !key_valid;
                FUNC_REMOVE: do_rem = key_valid;
                FUNC_UPDATE: begin
                    add_kind = blk_rdata[15:0];
                    add_orient = blk_rdata[18:16];
                    if (blk_rdata[15:0] == 16'd0) begin
                        do_rem = key_valid;
                    end else if (in_reg.neighbour_kind == 16'd0) begin
                        do_add = !key_valid;
                    end else begin
                        do_rem = key_valid;
                    end
                end
                default: ;
            endcase
        end
    end

    logic [SW-1:0] fs_top_m1;
    assign fs_top_m1 = SW'(free_top_reg - CW'(1));
    assign fs_raddr = fs_top_m1;
    assign inst_raddr = key_slot;
    assign fs_waddr = free_top_reg[SW-1:0];

    always_comb begin
        blk_we = 1'b0;
        blk_wdata = '0;
        key_we = 1'b0;
        key_wdata = key_rdata;
        inst_we = 1'b0;
        inst_waddr = slot_reg;
        inst_wdata = '0;
        fs_we = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                blk_we = 1'b1;
                key_we = 1'b1;
                key_wdata = '0;
            end
            ST_EXEC: begin
                if (is_set) begin
                    blk_we = 1'b1;
                    blk_wdata = {in_reg.block_orient, in_reg.block_kind};
                end
                if (do_add && (free_top_reg != '0 ||
                               used_len_reg != CW'(MAX_SLOTS))) begin
                    key_we = 1'b1;
                    key_wdata[face_c*(SW+1) + SW] = 1'b1;
                    key_wdata[face_c*(SW+1) +: SW] =
                        (free_top_reg != '0) ? fs_rdata : used_len_reg[SW-1:0];
                    inst_we = 1'b1;
                    inst_waddr = key_wdata[face_c*(SW+1) +: SW];
                    inst_wdata = '{x: in_reg.pos_x, y: in_reg.pos_y,
                                   z: in_reg.pos_z, face: in_reg.face_num,
                                   orient: add_orient, kind: add_kind};
                end
            end
            ST_REM: begin
                key_we = 1'b1;
                key_wdata[face_c*(SW+1) + SW] = 1'b0;
                inst_we = 1'b1;
                inst_wdata = inst_rdata;
                inst_wdata.kind = 16'd0;
                fs_we = (free_top_reg != CW'(MAX_SLOTS));
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        in_next = in_reg;
        clr_next = clr_reg;
        free_top_next = free_top_reg;
        used_len_next = used_len_reg;
        removed_next = removed_reg;
        slot_next = slot_reg;
        res_next = res_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + CAW'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && can_take) begin
                    in_next = s_data;
                    if (in_range) begin
                        state_next = ST_READ;
                    end else begin
                        res_next = '0;
                        res_next.removed_count = removed_reg;
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_WAIT;
                res_next = '0;
                res_next.removed_count = removed_reg;
                if (do_rem) begin
                    slot_next = key_slot;
                    state_next = ST_IREAD;
                end else if (do_add) begin
                    res_next.out_x = in_reg.pos_x;
                    res_next.out_y = in_reg.pos_y;
                    res_next.out_z = in_reg.pos_z;
                    res_next.out_face = in_reg.face_num;
                    res_next.out_orient = add_orient;
                    res_next.out_kind = add_kind;
                    if (free_top_reg != '0) begin
                        free_top_next = free_top_reg - CW'(1);
                        if (removed_reg != '0) begin
                            removed_next = removed_reg - 16'd1;
                            res_next.removed_count = removed_reg - 16'd1;
                        end
                        res_next.action = ACT_REUSE;
                        res_next.slot_index = 15'(fs_rdata);
                    end else if (used_len_reg != CW'(MAX_SLOTS)) begin
                        used_len_next = used_len_reg + CW'(1);
                        res_next.action = ACT_APPEND;
                        res_next.slot_index = 15'(used_len_reg[SW-1:0]);
                    end else begin
                        res_next = '0;
                        res_next.removed_count = removed_reg;
                        res_next.full_error = 1'b1;
                    end
                end
            end
            ST_IREAD: begin
                state_next = ST_REM;
            end
            ST_REM: begin
                state_next = ST_WAIT;
                if (removed_reg != 16'hFFFF) begin
                    removed_next = removed_reg + 16'd1;
                    res_next.removed_count = removed_reg + 16'd1;
                end
                if (free_top_reg != CW'(MAX_SLOTS)) begin
                    free_top_next = free_top_reg + CW'(1);
                end
                res_next.action = ACT_REMOVE;
                res_next.slot_index = 15'(slot_reg);
                res_next.out_x = inst_rdata.x;
                res_next.out_y = inst_rdata.y;
                res_next.out_z = inst_rdata.z;
                res_next.out_face = inst_rdata.face;
                res_next.out_orient = inst_rdata.orient;
            end
            ST_WAIT: begin
                if (!out_valid_reg || m_ready) begin
                    out_next = res_reg;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            free_top_reg <= '0;
            used_len_reg <= '0;
            removed_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            free_top_reg <= free_top_next;
            used_len_reg <= used_len_next;
            removed_reg <= removed_next;
            out_valid_reg <= out_valid_next;
        end
        in_reg <= in_next;
        slot_reg <= slot_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    `FIST_ASSERT_IMP(a_ft_bound, aclk, aresetn, 1'b1, free_top_reg <= CW'(MAX_SLOTS))
    `FIST_ASSERT_IMP(a_ul_bound, aclk, aresetn, 1'b1, used_len_reg <= CW'(MAX_SLOTS))
    `FIST_ASSERT_NEXT(a_rem_out, aclk, aresetn, state_reg == ST_REM, res_reg.action == ACT_REMOVE)
    `FIST_ASSERT_IMP(a_no_take, aclk, aresetn, state_reg != ST_IDLE, !s_ready)
endmodule

>>> rtl/core/fist_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module fist_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> tb/testbench.sv
// Self-checking testbench for the face instance slot table top level.
// Depends on fist_pkg and face_instance_slot_table_top; drives random and directed
// words and checks every result against an internal prediction of the slot table.
`timescale 1ns / 100ps
module testbench;
    import fist_pkg::*;

    localparam int SIDE = 16;
    localparam int MAX_SLOTS = 32768;
    localparam int CELLS = SIDE * SIDE * SIDE;
    localparam int KEYS = CELLS * NUM_FACES;
    localparam int CYCLE_LIMIT = 400000;

    class slot_table_board;
        logic [15:0] cell_kind [CELLS];
        logic [2:0]  cell_orient [CELLS];
        bit          key_live [KEYS];
        logic [14:0] key_slot [KEYS];
        inst_t       slots [MAX_SLOTS];
        logic [14:0] free_list [MAX_SLOTS];
        int unsigned free_top;
        int unsigned used_len;
        int unsigned removed_cnt;
        out_word_t   pending [$];
        int          errors;

        function new();
            for (int i = 0; i < CELLS; i++) begin
                cell_kind[i] = '0;
                cell_orient[i] = '0;
            end
            for (int i = 0; i < KEYS; i++) begin
                key_live[i] = 0;
                key_slot[i] = '0;
            end
            free_top = 0;
            used_len = 0;
            removed_cnt = 0;
            errors = 0;
        endfunction

        function out_word_t empty_word(bit full);
            out_word_t r;
            r = '0;
            r.removed_count = removed_cnt[15:0];
            r.full_error = full;
            return r;
        endfunction

        function out_word_t add_face(int key, inst_t e);
            out_word_t r;
            logic [14:0] s;
            logic [1:0] act;
            if (key_live[key]) return empty_word(0);
            if (free_top > 0) begin
                free_top--;
                s = free_list[free_top];
                if (removed_cnt > 0) removed_cnt--;
                act = ACT_REUSE;
            end else if (used_len < MAX_SLOTS) begin
                s = used_len[14:0];
                used_len++;
                act = ACT_APPEND;
            end else begin
                return empty_word(1);
            end
            slots[s] = e;
            key_live[key] = 1;
            key_slot[key] = s;
            r = empty_word(0);
            r.action = act;
            r.slot_index = s;
            {r.out_x, r.out_y, r.out_z, r.out_face, r.out_orient, r.out_kind} = e;
            return r;
        endfunction

        function out_word_t remove_face(int key);
            out_word_t r;
            logic [14:0] s;
            if (!key_live[key]) return empty_word(0);
            s = key_slot[key];
            slots[s].kind = '0;
            key_live[key] = 0;
            if (removed_cnt < 65535) removed_cnt++;
            if (free_top < MAX_SLOTS) begin
                free_list[free_top] = s;
                free_top++;
            end
            r = empty_word(0);
            r.action = ACT_REMOVE;
            r.slot_index = s;
            {r.out_x, r.out_y, r.out_z, r.out_face, r.out_orient, r.out_kind} = slots[s];
            return r;
        endfunction

        function void note_word(in_word_t w);
            int cell_idx;
            int key;
            inst_t e;
            out_word_t r;
            cell_idx = (w.pos_z * SIDE + w.pos_y) * SIDE + w.pos_x;
            key = cell_idx * NUM_FACES + w.face_num;
            if (w.func == FUNC_SET) begin
                cell_kind[cell_idx] = w.block_kind;
                cell_orient[cell_idx] = w.block_orient;
                r = empty_word(0);
            end else if (w.face_num > 5) begin
                r = empty_word(0);
            end else if (w.func == FUNC_ADD) begin
                e = '{w.pos_x, w.pos_y, w.pos_z, w.face_num, w.block_orient, w.block_kind};
                r = add_face(key, e);
            end else if (w.func == FUNC_REMOVE) begin
                r = remove_face(key);
            end else if (cell_kind[cell_idx] == 0) begin
                r = remove_face(key);
            end else if (w.neighbour_kind == 0 && !key_live[key]) begin
                e = '{w.pos_x, w.pos_y, w.pos_z, w.face_num, cell_orient[cell_idx],
                      cell_kind[cell_idx]};
                r = add_face(key, e);
            end else if (w.neighbour_kind != 0 && key_live[key]) begin
                r = remove_face(key);
            end else begin
                r = empty_word(0);
            end
            pending.insert(pending.size(), r);
        endfunction

        function void check_word(out_word_t got);
            out_word_t exp;
            if (pending.size() == 0) begin
                $error("result with no expectation: %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.action !== exp.action) begin
                $error("action exp %0d got %0d", exp.action, got.action); errors++;
            end
            if (got.slot_index !== exp.slot_index) begin
                $error("slot_index exp %0d got %0d", exp.slot_index, got.slot_index);
                errors++;
            end
            if (got.out_x !== exp.out_x) begin
                $error("out_x exp %0d got %0d", exp.out_x, got.out_x); errors++;
            end
            if (got.out_y !== exp.out_y) begin
                $error("out_y exp %0d got %0d", exp.out_y, got.out_y); errors++;
            end
            if (got.out_z !== exp.out_z) begin
                $error("out_z exp %0d got %0d", exp.out_z, got.out_z); errors++;
            end
            if (got.out_face !== exp.out_face) begin
                $error("out_face exp %0d got %0d", exp.out_face, got.out_face); errors++;
            end
            if (got.out_orient !== exp.out_orient) begin
                $error("out_orient exp %0d got %0d", exp.out_orient, got.out_orient);
                errors++;
            end
            if (got.out_kind !== exp.out_kind) begin
                $error("out_kind exp %0d got %0d", exp.out_kind, got.out_kind); errors++;
            end
            if (got.removed_count !== exp.removed_count) begin
                $error("removed_count exp %0d got %0d", exp.removed_count,
                       got.removed_count);
                errors++;
            end
            if (got.full_error !== exp.full_error) begin
                $error("full_error exp %0d got %0d", exp.full_error, got.full_error);
                errors++;
            end
        endfunction
    endclass

    logic      aclk = 0;
    logic      aresetn = 0;
    logic      s_valid = 0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 0;
    out_word_t m_data;

    slot_table_board board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;

    face_instance_slot_table_top #(.SIDE(SIDE), .MAX_SLOTS(MAX_SLOTS)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[face_instance_slot_table_top] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_word(m_data);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_word(in_word_t w);
        int gap;
        gap = 0;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_word(w);
    endtask

    function automatic in_word_t make_word(logic [1:0] f, int x, int y, int z, int fc,
                                           int kind, int orient, int nkind);
        in_word_t w;
        w.func = f;
        w.pos_x = 4'(x); w.pos_y = 4'(y); w.pos_z = 4'(z);
        w.face_num = 3'(fc);
        w.block_kind = 16'(kind);
        w.block_orient = 3'(orient);
        w.neighbour_kind = 16'(nkind);
        return w;
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        int r;
        w = '0;
        r = $urandom_range(99);
        w.func = (r < 35) ? FUNC_ADD : (r < 60) ? FUNC_REMOVE :
                 (r < 85) ? FUNC_UPDATE : FUNC_SET;
        w.pos_x = 4'($urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(1));
        w.pos_y = 4'($urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(1));
        w.pos_z = 4'($urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(1));
        w.face_num = 3'($urandom_range(9) == 0 ? $urandom_range(7) : $urandom_range(5));
        w.block_kind = 16'($urandom_range(3) == 0 ? 0 : $urandom_range(65535));
        w.block_orient = 3'($urandom_range(7));
        w.neighbour_kind = 16'($urandom_range(1) ? 0 : $urandom_range(65535));
        return w;
    endfunction

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_word(make_word(FUNC_ADD, 0, 0, 0, 0, 16'hFFFF, 7, 0));
        send_word(make_word(FUNC_ADD, 0, 0, 0, 0, 5, 1, 0));
        send_word(make_word(FUNC_ADD, 15, 15, 15, 5, 1, 0, 16'hFFFF));
        send_word(make_word(FUNC_ADD, 3, 4, 5, 6, 1, 2, 0));
        send_word(make_word(FUNC_ADD, 3, 4, 5, 7, 1, 2, 0));
        send_word(make_word(FUNC_REMOVE, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(FUNC_REMOVE, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(FUNC_REMOVE, 15, 15, 15, 7, 0, 0, 0));
        send_word(make_word(FUNC_ADD, 1, 2, 3, 4, 16'h8001, 5, 0));
        send_word(make_word(FUNC_ADD, 1, 2, 3, 3, 16'h0002, 3, 0));
        send_word(make_word(FUNC_SET, 7, 7, 7, 7, 16'hFFFF, 7, 16'hFFFF));
        send_word(make_word(FUNC_UPDATE, 7, 7, 7, 2, 0, 0, 0));
        send_word(make_word(FUNC_UPDATE, 7, 7, 7, 2, 0, 0, 0));
        send_word(make_word(FUNC_UPDATE, 7, 7, 7, 2, 0, 0, 16'h0001));
        send_word(make_word(FUNC_UPDATE, 7, 7, 7, 6, 0, 0, 0));
        send_word(make_word(FUNC_UPDATE, 8, 8, 8, 1, 0, 0, 0));
        send_word(make_word(FUNC_ADD, 8, 8, 8, 1, 9, 4, 0));
        send_word(make_word(FUNC_UPDATE, 8, 8, 8, 1, 0, 0, 0));
        send_word(make_word(FUNC_SET, 7, 7, 7, 0, 0, 0, 0));
        send_word(make_word(FUNC_UPDATE, 7, 7, 7, 2, 0, 0, 0));

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = (p == 1 || p == 3) ? (p == 1 ? 66 : 10) : 0;
            recv_stall_pct = (p == 2) ? 66 : (p == 3 ? 10 : 0);
            for (int i = 0; i < 480; i++) send_word(random_word());
            s_valid <= 0;
            while (board.pending.size() > 0) @(posedge aclk);
        end

        repeat (20) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("[face_instance_slot_table_top] OK");
        else
            $display("[face_instance_slot_table_top] ERROR");
        $finish;
    end
endmodule
